@@ design/cda_pkg.sv @@
// types, constants, calendar tables and microcode rom for the calendar date adder
`default_nettype none
package cda_pkg;

	// request payloads
	typedef struct packed {
		logic [1:0]  command;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [15:0] day_delta;
		logic [9:0]  month_delta;
		logic [9:0]  year_delta;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  cur_day;
		logic [3:0]  cur_month;
		logic [13:0] cur_year;
		logic [21:0] day_count;
		logic [1:0]  status;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_SET     = 2'd0,
		CMD_ADVANCE = 2'd1,
		CMD_DIFF    = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_AFTER    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// calendar constants
	localparam logic [3:0]  MONTHS        = 4'd12;
	localparam logic [4:0]  LONG_MONTH    = 5'd31;
	localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
	localparam logic [6:0]  LEAPS_PER_CYC = 7'd97;
	localparam logic [8:0]  CYCLE_YEARS   = 9'd400;
	localparam logic [21:0] COUNT_MAX     = 22'h3FFFFF;

	// microcode
	localparam int UPC_W = 5;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD_IN,
		OP_LOAD_ADV,
		OP_M_CARRY,
		OP_INIT_MOD,
		OP_MOD_SUB,
		OP_DAY_CARRY,
		OP_SAT,
		OP_SER_MUL,
		OP_SER_Q,
		OP_SER_FIN,
		OP_LOAD_STORED,
		OP_SET_COUNT,
		OP_ST_AFTER,
		OP_ST_BAD,
		OP_STORE,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_CMD_ADV,
		C_CMD_NOP,
		C_INVALID,
		C_M_LE12,
		C_Y_OVER,
		C_R_LT400,
		C_DAY_EXIT,
		C_Y_OK,
		C_NOT_DIFF,
		C_OVF,
		C_SA_GT_ACC,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [UPC_W-1:0] target;
		logic             hold;
	} ucode_t;

	// program addresses
	localparam logic [UPC_W-1:0] A_DISPATCH = 5'd0;
	localparam logic [UPC_W-1:0] A_CHK_NOP  = 5'd1;
	localparam logic [UPC_W-1:0] A_CHK_BAD  = 5'd2;
	localparam logic [UPC_W-1:0] A_LOAD_IN  = 5'd3;
	localparam logic [UPC_W-1:0] A_ADV      = 5'd4;
	localparam logic [UPC_W-1:0] A_MCARRY   = 5'd5;
	localparam logic [UPC_W-1:0] A_YCHK     = 5'd6;
	localparam logic [UPC_W-1:0] A_MOD      = 5'd7;
	localparam logic [UPC_W-1:0] A_DAY      = 5'd8;
	localparam logic [UPC_W-1:0] A_YOK      = 5'd9;
	localparam logic [UPC_W-1:0] A_SAT      = 5'd10;
	localparam logic [UPC_W-1:0] A_POST     = 5'd11;
	localparam logic [UPC_W-1:0] A_OVFCHK   = 5'd12;
	localparam logic [UPC_W-1:0] A_MUL_A    = 5'd13;
	localparam logic [UPC_W-1:0] A_Q_A      = 5'd14;
	localparam logic [UPC_W-1:0] A_FIN_A    = 5'd15;
	localparam logic [UPC_W-1:0] A_LOAD_ST  = 5'd16;
	localparam logic [UPC_W-1:0] A_INIT_B   = 5'd17;
	localparam logic [UPC_W-1:0] A_MOD_B    = 5'd18;
	localparam logic [UPC_W-1:0] A_MUL_B    = 5'd19;
	localparam logic [UPC_W-1:0] A_Q_B      = 5'd20;
	localparam logic [UPC_W-1:0] A_FIN_B    = 5'd21;
	localparam logic [UPC_W-1:0] A_CMP      = 5'd22;
	localparam logic [UPC_W-1:0] A_CNT_OUT  = 5'd23;
	localparam logic [UPC_W-1:0] A_AFTER    = 5'd24;
	localparam logic [UPC_W-1:0] A_BAD      = 5'd25;
	localparam logic [UPC_W-1:0] A_COMMIT   = 5'd26;
	localparam logic [UPC_W-1:0] A_DONE     = 5'd27;

	// a step runs its op unless it branches; an always step runs its op and branches
	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] pc);
		ucode_t u;
		u = '{op: OP_NOP, cond: C_ALWAYS, target: A_DONE, hold: 1'b0};
		case (pc)
			A_DISPATCH: u = '{op: OP_NOP,         cond: C_CMD_ADV,   target: A_ADV,     hold: 1'b0};
			A_CHK_NOP:  u = '{op: OP_NOP,         cond: C_CMD_NOP,   target: A_DONE,    hold: 1'b0};
			A_CHK_BAD:  u = '{op: OP_NOP,         cond: C_INVALID,   target: A_BAD,     hold: 1'b0};
			A_LOAD_IN:  u = '{op: OP_LOAD_IN,     cond: C_ALWAYS,    target: A_MCARRY,  hold: 1'b0};
			A_ADV:      u = '{op: OP_LOAD_ADV,    cond: C_NEVER,     target: A_MCARRY,  hold: 1'b0};
			A_MCARRY:   u = '{op: OP_M_CARRY,     cond: C_M_LE12,    target: A_YCHK,    hold: 1'b1};
			A_YCHK:     u = '{op: OP_INIT_MOD,    cond: C_Y_OVER,    target: A_SAT,     hold: 1'b0};
			A_MOD:      u = '{op: OP_MOD_SUB,     cond: C_R_LT400,   target: A_DAY,     hold: 1'b1};
			A_DAY:      u = '{op: OP_DAY_CARRY,   cond: C_DAY_EXIT,  target: A_YOK,     hold: 1'b1};
			A_YOK:      u = '{op: OP_NOP,         cond: C_Y_OK,      target: A_POST,    hold: 1'b0};
			A_SAT:      u = '{op: OP_SAT,         cond: C_NEVER,     target: A_POST,    hold: 1'b0};
			A_POST:     u = '{op: OP_NOP,         cond: C_NOT_DIFF,  target: A_COMMIT,  hold: 1'b0};
			A_OVFCHK:   u = '{op: OP_NOP,         cond: C_OVF,       target: A_AFTER,   hold: 1'b0};
			A_MUL_A:    u = '{op: OP_SER_MUL,     cond: C_NEVER,     target: A_Q_A,     hold: 1'b0};
			A_Q_A:      u = '{op: OP_SER_Q,       cond: C_NEVER,     target: A_FIN_A,   hold: 1'b0};
			A_FIN_A:    u = '{op: OP_SER_FIN,     cond: C_NEVER,     target: A_LOAD_ST, hold: 1'b0};
			A_LOAD_ST:  u = '{op: OP_LOAD_STORED, cond: C_NEVER,     target: A_INIT_B,  hold: 1'b0};
			A_INIT_B:   u = '{op: OP_INIT_MOD,    cond: C_NEVER,     target: A_MOD_B,   hold: 1'b0};
			A_MOD_B:    u = '{op: OP_MOD_SUB,     cond: C_R_LT400,   target: A_MUL_B,   hold: 1'b1};
			A_MUL_B:    u = '{op: OP_SER_MUL,     cond: C_NEVER,     target: A_Q_B,     hold: 1'b0};
			A_Q_B:      u = '{op: OP_SER_Q,       cond: C_NEVER,     target: A_FIN_B,   hold: 1'b0};
			A_FIN_B:    u = '{op: OP_SER_FIN,     cond: C_NEVER,     target: A_CMP,     hold: 1'b0};
			A_CMP:      u = '{op: OP_SET_COUNT,   cond: C_SA_GT_ACC, target: A_AFTER,   hold: 1'b0};
			A_CNT_OUT:  u = '{op: OP_NOP,         cond: C_ALWAYS,    target: A_DONE,    hold: 1'b0};
			A_AFTER:    u = '{op: OP_ST_AFTER,    cond: C_ALWAYS,    target: A_DONE,    hold: 1'b0};
			A_BAD:      u = '{op: OP_ST_BAD,      cond: C_ALWAYS,    target: A_DONE,    hold: 1'b0};
			A_COMMIT:   u = '{op: OP_STORE,       cond: C_NEVER,     target: A_DONE,    hold: 1'b0};
			A_DONE:     u = '{op: OP_EMIT,        cond: C_OUT_BUSY,  target: A_DONE,    hold: 1'b0};
			default:    u = '{op: OP_NOP,         cond: C_ALWAYS,    target: A_DONE,    hold: 1'b0};
		endcase
		return u;
	endfunction

	// leap test on the year's position in the 400-year cycle
	function automatic logic is_leap400(input logic [8:0] r);
		return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		n = LONG_MONTH;
		case (m)
			4'd2:                       n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:    n = 5'd30;
			default:                    n = LONG_MONTH;
		endcase
		return n;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] n;
		n = 9'd0;
		case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

	// leap days before year r of a 400-year cycle: (r+3)/4 - (r+99)/100 + (r>0)
	function automatic logic [9:0] cycle_leaps(input logic [8:0] r);
		logic [9:0] q4;
		logic [2:0] cent;
		q4 = 10'((11'(r) + 11'd3) >> 2);
		if (r == 9'd0) begin
			cent = 3'd0;
		end else if (r <= 9'd100) begin
			cent = 3'd1;
		end else if (r <= 9'd200) begin
			cent = 3'd2;
		end else if (r <= 9'd300) begin
			cent = 3'd3;
		end else begin
			cent = 3'd4;
		end
		return q4 - 10'(cent) + 10'(r != 9'd0);
	endfunction

endpackage
`default_nettype wire

@@ design/cda_stream_if.sv @@
// valid/ready stream channel carrying one request payload
`default_nettype none
interface cda_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/calendar_date_adder.sv @@
// calendar date adder top level: microcoded sequencer and date datapath
`default_nettype none
// Keeps one Gregorian date (reset 1/1/0) and runs one command per input
// request: set loads and normalizes a date, advance adds year, month and day
// offsets and normalizes, difference returns the days from the input date
// forward to the stored date. Every request returns exactly one result with
// the stored date, the day count and a status (ok, invalid date, target after
// stored, year overflow with saturation to 31/12/MAX_YEAR). One request is in
// flight at a time; in_ch.ready is high whenever the sequencer is idle, even
// while a result still waits in the output register. The sequencer is a
// 28-step microcode rom driving one date datapath, one step per clock. Loop
// steps carry excess months into years 12 at a time, reduce the year to its
// position in the 400-year cycle by taking off 400 years at a time (twice
// for difference) and walk excess days into later months one month at a
// time. An invalid date or an unused command skips the date arithmetic. A
// result that cannot leave the output register holds the sequencer in its
// last step until the register frees.
module calendar_date_adder #(
	parameter int MAX_YEAR = 9999
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cda_stream_if.sink   in_ch,
	cda_stream_if.source out_ch
);

	localparam logic [14:0] MaxYearW = 15'(MAX_YEAR);

	// sequencer
	logic                       busy_q;
	logic [cda_pkg::UPC_W-1:0]  pc_q;
	logic [cda_pkg::UPC_W-1:0]  pc_next;
	cda_pkg::ucode_t            uw;
	logic                       cond_hit;
	logic                       run_op;
	logic                       in_acc;

	// stored date
	logic [4:0]  sd_q;
	logic [3:0]  sm_q;
	logic [13:0] sy_q;

	// working date: day up to 31+65535, month up to 12+1023, year past MAX_YEAR
	cda_pkg::in_item_t in_q;
	logic [16:0] d_q;
	logic [10:0] m_q;
	logic [14:0] y_q;
	logic [14:0] r_q;     // year remainder in its 400-year cycle
	logic [5:0]  q_q;     // count of whole 400-year cycles
	logic [23:0] acc_q;   // day serial being built
	logic [23:0] sa_q;    // serial of the difference target
	logic        ovf_q;
	cda_pkg::status_t  st_q;
	logic [21:0]       cnt_q;

	// result register
	cda_pkg::out_item_t out_q;
	logic               out_valid_q;

	// datapath helpers
	logic        leap;
	logic [4:0]  dim;
	logic [23:0] diff;

	assign in_acc       = in_ch.valid && in_ch.ready;
	assign in_ch.ready  = !busy_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	always_comb begin
		leap = cda_pkg::is_leap400(r_q[8:0]);
		dim  = cda_pkg::month_days(m_q[3:0], leap);
		diff = acc_q - sa_q;
	end

	// branch conditions of the current control word
	always_comb begin
		uw = cda_pkg::ucode_rom(pc_q);
		case (uw.cond)
			cda_pkg::C_NEVER:     cond_hit = 1'b0;
			cda_pkg::C_ALWAYS:    cond_hit = 1'b1;
			cda_pkg::C_CMD_ADV:   cond_hit = (in_q.command == cda_pkg::CMD_ADVANCE);
			cda_pkg::C_CMD_NOP:   cond_hit = (in_q.command == cda_pkg::CMD_NOP);
			cda_pkg::C_INVALID:   cond_hit = (in_q.day == 5'd0) || (in_q.month == 4'd0)
				|| (in_q.month > cda_pkg::MONTHS) || (15'(in_q.year) > MaxYearW);
			cda_pkg::C_M_LE12:    cond_hit = (m_q <= 11'(cda_pkg::MONTHS));
			cda_pkg::C_Y_OVER:    cond_hit = (y_q > MaxYearW);
			cda_pkg::C_R_LT400:   cond_hit = (r_q < 15'(cda_pkg::CYCLE_YEARS));
			cda_pkg::C_DAY_EXIT:  cond_hit = (y_q > MaxYearW) || (d_q <= 17'(dim));
			cda_pkg::C_Y_OK:      cond_hit = (y_q <= MaxYearW);
			cda_pkg::C_NOT_DIFF:  cond_hit = (in_q.command != cda_pkg::CMD_DIFF);
			cda_pkg::C_OVF:       cond_hit = ovf_q;
			cda_pkg::C_SA_GT_ACC: cond_hit = (sa_q > acc_q);
			cda_pkg::C_OUT_BUSY:  cond_hit = out_valid_q && !out_ch.ready;
			default:              cond_hit = 1'b0;
		endcase
	end

	// next step: branch, hold in a loop step, or fall through
	always_comb begin
		run_op = busy_q && (!cond_hit || (uw.cond == cda_pkg::C_ALWAYS));
		if (cond_hit) begin
			pc_next = uw.target;
		end else if (uw.hold) begin
			pc_next = pc_q;
		end else begin
			pc_next = pc_q + 1'b1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= cda_pkg::A_DISPATCH;
			out_valid_q <= 1'b0;
			sd_q        <= 5'd1;
			sm_q        <= 4'd1;
			sy_q        <= 14'd0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
				pc_q   <= cda_pkg::A_DISPATCH;
			end else if (busy_q) begin
				pc_q <= pc_next;
				if (run_op && uw.op == cda_pkg::OP_EMIT) begin
					busy_q <= 1'b0;
				end
			end
			// a normalized date always fits the stored widths
			if (run_op && uw.op == cda_pkg::OP_STORE) begin
				sd_q <= d_q[4:0];
				sm_q <= m_q[3:0];
				sy_q <= y_q[13:0];
			end
			if (run_op && uw.op == cda_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_q  <= in_ch.data;
			ovf_q <= 1'b0;
			st_q  <= cda_pkg::ST_OK;
			cnt_q <= 22'd0;
		end else if (run_op) begin
			case (uw.op)
				cda_pkg::OP_LOAD_IN: begin
					d_q <= 17'(in_q.day);
					m_q <= 11'(in_q.month);
					y_q <= 15'(in_q.year);
				end
				cda_pkg::OP_LOAD_ADV: begin
					d_q <= 17'(sd_q) + 17'(in_q.day_delta);
					m_q <= 11'(sm_q) + 11'(in_q.month_delta);
					y_q <= 15'(sy_q) + 15'(in_q.year_delta);
				end
				cda_pkg::OP_M_CARRY: begin
					m_q <= m_q - 11'(cda_pkg::MONTHS);
					y_q <= y_q + 15'd1;
				end
				cda_pkg::OP_INIT_MOD: begin
					r_q <= y_q;
					q_q <= 6'd0;
				end
				cda_pkg::OP_MOD_SUB: begin
					r_q <= r_q - 15'(cda_pkg::CYCLE_YEARS);
					q_q <= q_q + 6'd1;
				end
				cda_pkg::OP_DAY_CARRY: begin
					d_q <= d_q - 17'(dim);
					if (m_q == 11'(cda_pkg::MONTHS)) begin
						m_q <= 11'd1;
						y_q <= y_q + 15'd1;
						// keep the cycle position in step with the year
						if (r_q == 15'(cda_pkg::CYCLE_YEARS - 9'd1)) begin
							r_q <= 15'd0;
							q_q <= q_q + 6'd1;
						end else begin
							r_q <= r_q + 15'd1;
						end
					end else begin
						m_q <= m_q + 11'd1;
					end
				end
				cda_pkg::OP_SAT: begin
					d_q   <= 17'(cda_pkg::LONG_MONTH);
					m_q   <= 11'(cda_pkg::MONTHS);
					y_q   <= MaxYearW;
					ovf_q <= 1'b1;
				end
				cda_pkg::OP_SER_MUL: begin
					acc_q <= 24'(y_q) * 24'(cda_pkg::DAYS_PER_YEAR);
				end
				cda_pkg::OP_SER_Q: begin
					acc_q <= acc_q + 24'(q_q) * 24'(cda_pkg::LEAPS_PER_CYC);
				end
				cda_pkg::OP_SER_FIN: begin
					acc_q <= acc_q + 24'(cda_pkg::cycle_leaps(r_q[8:0]))
						+ 24'(cda_pkg::days_before(m_q[3:0])) + 24'(d_q)
						+ 24'((m_q > 11'd2) && leap);
				end
				cda_pkg::OP_LOAD_STORED: begin
					sa_q <= acc_q;
					d_q  <= 17'(sd_q);
					m_q  <= 11'(sm_q);
					y_q  <= 15'(sy_q);
				end
				cda_pkg::OP_SET_COUNT: begin
					cnt_q <= (diff > 24'(cda_pkg::COUNT_MAX)) ? cda_pkg::COUNT_MAX : diff[21:0];
				end
				cda_pkg::OP_ST_AFTER: st_q <= cda_pkg::ST_AFTER;
				cda_pkg::OP_ST_BAD:   st_q <= cda_pkg::ST_INVALID;
				cda_pkg::OP_STORE: begin
					st_q <= ovf_q ? cda_pkg::ST_OVERFLOW : cda_pkg::ST_OK;
				end
				cda_pkg::OP_EMIT: begin
					out_q.cur_day   <= sd_q;
					out_q.cur_month <= sm_q;
					out_q.cur_year  <= sy_q;
					out_q.day_count <= cnt_q;
					out_q.status    <= st_q;
				end
				default: begin
				end
			endcase
		end
	end

	// stored date is always a legal date within range
	a_stored_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(sd_q != 5'd0) && (sm_q != 4'd0) && (sm_q <= cda_pkg::MONTHS)
		&& (15'(sy_q) <= MaxYearW))
		else $error("stored date out of range");

	// the month walk only runs with the cycle position reduced
	a_cycle_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (pc_q == cda_pkg::A_DAY) |-> (r_q < 15'(cda_pkg::CYCLE_YEARS)))
		else $error("cycle position not reduced in month walk");

	// a result only appears at the end of a sequenced request
	a_result_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q) && !busy_q)
		else $error("result without a finished request");

	// a failing status never carries a day count
	a_count_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status != cda_pkg::ST_OK) |-> (out_q.day_count == 22'd0))
		else $error("day count with failing status");

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// self-checking testbench for the calendar date adder: directed dates, then random traffic
`default_nettype none
module tb;
	import cda_pkg::*;

	// calendar limit used by both the dut and the date predictor
	localparam int unsigned LAST_YEAR = 9999;
	// an advance by a full 65535-day offset walks about 2150 months, so this
	// leaves a wide margin over the slowest request plus a long output stall
	localparam int unsigned IDLE_LIMIT = 20000;
	// quiet cycles after the last result, to catch any stray output
	localparam int unsigned TAIL_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cda_stream_if #(.payload_t(in_item_t))  in_ch ();
	cda_stream_if #(.payload_t(out_item_t)) out_ch ();

	calendar_date_adder #(.MAX_YEAR(LAST_YEAR)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// 12 time unit period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predicted date register, follows every accepted request in order
	int unsigned cal_day = 1;
	int unsigned cal_month = 1;
	int unsigned cal_year = 0;

	// results predicted but not yet seen on the output channel
	out_item_t expected_dates[$];

	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	int unsigned cmd_seen[4] = '{0, 0, 0, 0};
	int unsigned status_seen[4] = '{0, 0, 0, 0};

	// idling odds in percent, changed per phase
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;

	// gregorian leap rule with the 400-year exception
	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
		case (m)
			2:          return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:    return 31;
		endcase
	endfunction

	// fold months into years, then walk excess days month by month;
	// on year overflow the date pins to 31/12/LAST_YEAR and 0 is returned
	function automatic bit normalize_date(inout int unsigned d, inout int unsigned m,
			inout int unsigned y);
		bit ok;
		y = y + (m - 1) / 12;
		m = (m - 1) % 12 + 1;
		ok = (y <= LAST_YEAR);
		while (ok && d > month_length(m, y)) begin
			d = d - month_length(m, y);
			m = m + 1;
			if (m > 12) begin
				m = 1;
				y = y + 1;
				ok = (y <= LAST_YEAR);
			end
		end
		if (!ok) begin
			d = 31;
			m = 12;
			y = LAST_YEAR;
		end
		return ok;
	endfunction

	// day number counted from 1/1/0, for a valid date
	function automatic int unsigned day_serial(input int unsigned d, input int unsigned m,
			input int unsigned y);
		int unsigned n;
		n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + d;
		for (int unsigned k = 1; k < m; k++) begin
			n += month_length(k, y);
		end
		return n;
	endfunction

	function automatic bit date_in_range(input int unsigned d, input int unsigned m,
			input int unsigned y);
		return d >= 1 && m >= 1 && m <= 12 && y <= LAST_YEAR;
	endfunction

	// expected result of one request; updates the predicted date register
	function automatic out_item_t predict_calendar(input in_item_t req);
		out_item_t res;
		int unsigned d, m, y, a, b, span;
		status_t st;
		d = req.day;
		m = req.month;
		y = req.year;
		span = 0;
		st = ST_OK;
		case (cmd_t'(req.command))
			CMD_SET: begin
				if (!date_in_range(d, m, y)) begin
					st = ST_INVALID;
				end else begin
					if (!normalize_date(d, m, y))
						st = ST_OVERFLOW;
					cal_day = d;
					cal_month = m;
					cal_year = y;
				end
			end
			CMD_ADVANCE: begin
				d = cal_day + req.day_delta;
				m = cal_month + req.month_delta;
				y = cal_year + req.year_delta;
				if (!normalize_date(d, m, y))
					st = ST_OVERFLOW;
				cal_day = d;
				cal_month = m;
				cal_year = y;
			end
			CMD_DIFF: begin
				if (!date_in_range(d, m, y)) begin
					st = ST_INVALID;
				end else if (!normalize_date(d, m, y)) begin
					// a target pushed past the last year lies after any stored date
					st = ST_AFTER;
				end else begin
					a = day_serial(d, m, y);
					b = day_serial(cal_day, cal_month, cal_year);
					if (a > b) begin
						st = ST_AFTER;
					end else begin
						span = b - a;
						if (span > COUNT_MAX)
							span = COUNT_MAX;
					end
				end
			end
			default: ;
		endcase
		res.cur_day = 5'(cal_day);
		res.cur_month = 4'(cal_month);
		res.cur_year = 14'(cal_year);
		res.day_count = 22'(span);
		res.status = st;
		return res;
	endfunction

	task automatic check_result(input out_item_t got);
		out_item_t want;
		status_seen[got.status]++;
		if (expected_dates.size() == 0) begin
			$error("result with no request pending: %0d/%0d/%0d status %0d",
				got.cur_day, got.cur_month, got.cur_year, got.status);
			mismatches++;
		end else begin
			want = expected_dates.pop_front();
			if (got.cur_day !== want.cur_day) begin
				$error("cur_day: expected %0d, got %0d", want.cur_day, got.cur_day);
				mismatches++;
			end
			if (got.cur_month !== want.cur_month) begin
				$error("cur_month: expected %0d, got %0d", want.cur_month, got.cur_month);
				mismatches++;
			end
			if (got.cur_year !== want.cur_year) begin
				$error("cur_year: expected %0d, got %0d", want.cur_year, got.cur_year);
				mismatches++;
			end
			if (got.day_count !== want.day_count) begin
				$error("day_count: expected %0d, got %0d", want.day_count, got.day_count);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
		end
	endtask

	// both channels are sampled at the rising edge, before this edge's updates land;
	// results are checked before the new request is predicted, the order does not
	// matter since one request is in flight at a time
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			check_result(out_ch.data);
		if (arst_n && in_ch.valid && in_ch.ready) begin
			cmd_seen[in_ch.data.command]++;
			expected_dates.push_back(predict_calendar(in_ch.data));
		end
	end

	// output side: random stalls at the phase's rate
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog: cycles in a row in which neither channel moves a request
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_item_t make_request(input cmd_t op, input int unsigned d,
			input int unsigned m, input int unsigned y, input int unsigned dd,
			input int unsigned md, input int unsigned yd);
		in_item_t req;
		req.command = op;
		req.day = 5'(d);
		req.month = 4'(m);
		req.year = 14'(y);
		req.day_delta = 16'(dd);
		req.month_delta = 10'(md);
		req.year_delta = 10'(yd);
		return req;
	endfunction

	// one request on the input channel; valid stays high after acceptance
	// so the next request can follow back to back, any wait lowers it first
	task automatic send_request(input in_item_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= req;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	// sender holds off until every predicted result has been seen
	task automatic wait_for_results();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_dates.size() != 0);
	endtask

	// reset date, and a no-op with every field at its top value
	task automatic test_reset_state();
		send_request(make_request(CMD_NOP, 31, 15, 16383, 65535, 1023, 1023));
		send_request(make_request(CMD_DIFF, 1, 1, 0, 0, 0, 0));
	endtask

	// leap day in a 400-year leap, leap day in a century non-leap, days past
	// month end, last valid date
	task automatic test_set_dates();
		send_request(make_request(CMD_SET, 29, 2, 2000, 0, 0, 0));
		send_request(make_request(CMD_SET, 29, 2, 1900, 0, 0, 0));
		send_request(make_request(CMD_SET, 31, 4, 2023, 0, 0, 0));
		send_request(make_request(CMD_SET, 31, 12, LAST_YEAR, 0, 0, 0));
	endtask

	// every way a set or a difference date can be out of range
	task automatic test_invalid_dates();
		send_request(make_request(CMD_SET, 0, 6, 2020, 0, 0, 0));
		send_request(make_request(CMD_SET, 15, 0, 2020, 0, 0, 0));
		send_request(make_request(CMD_SET, 15, 13, 2020, 0, 0, 0));
		send_request(make_request(CMD_DIFF, 15, 15, 2020, 0, 0, 0));
		send_request(make_request(CMD_SET, 1, 1, LAST_YEAR + 1, 0, 0, 0));
		send_request(make_request(CMD_DIFF, 1, 1, 16383, 0, 0, 0));
	endtask

	// month carry landing past the end of february, zero offsets, all offsets maxed
	task automatic test_advance();
		send_request(make_request(CMD_SET, 31, 1, 2024, 0, 0, 0));
		send_request(make_request(CMD_ADVANCE, 0, 0, 0, 0, 1, 0));
		send_request(make_request(CMD_ADVANCE, 0, 0, 0, 0, 0, 0));
		send_request(make_request(CMD_SET, 1, 1, 0, 0, 0, 0));
		send_request(make_request(CMD_ADVANCE, 0, 0, 0, 65535, 1023, 1023));
	endtask

	// largest span, a target past its month end, across a leap day, a later target
	task automatic test_difference();
		send_request(make_request(CMD_SET, 31, 12, LAST_YEAR, 0, 0, 0));
		send_request(make_request(CMD_DIFF, 1, 1, 0, 0, 0, 0));
		send_request(make_request(CMD_DIFF, 31, 11, LAST_YEAR, 0, 0, 0));
		send_request(make_request(CMD_SET, 1, 3, 2024, 0, 0, 0));
		send_request(make_request(CMD_DIFF, 29, 2, 2024, 0, 0, 0));
		send_request(make_request(CMD_DIFF, 2, 3, 2024, 0, 0, 0));
	endtask

	// year overflow by day walk, by year offset and by month carry
	task automatic test_overflow();
		send_request(make_request(CMD_SET, 31, 12, LAST_YEAR, 0, 0, 0));
		send_request(make_request(CMD_ADVANCE, 0, 0, 0, 1, 0, 0));
		send_request(make_request(CMD_SET, 1, 1, 9000, 0, 0, 0));
		send_request(make_request(CMD_ADVANCE, 0, 0, 0, 0, 0, 1023));
		send_request(make_request(CMD_SET, 1, 12, LAST_YEAR, 0, 0, 0));
		send_request(make_request(CMD_ADVANCE, 0, 0, 0, 0, 1, 0));
	endtask

	// mostly well-formed commands near the current date, with some raw noise;
	// unused fields always carry random bits
	function automatic in_item_t random_request();
		in_item_t req;
		int unsigned roll, back_max;
		roll = $urandom_range(99);
		req.day = 5'($urandom_range(1, 31));
		req.month = 4'($urandom_range(1, 12));
		case ($urandom_range(3))
			0:       req.year = 14'($urandom_range(LAST_YEAR));
			1:       req.year = 14'($urandom_range(LAST_YEAR - 9, LAST_YEAR));
			default: req.year = 14'($urandom_range(1900, 2100));
		endcase
		req.day_delta = 16'($urandom);
		req.month_delta = 10'($urandom);
		req.year_delta = 10'($urandom);
		if (roll < 5) begin
			// raw noise over the whole field ranges
			req.command = 2'($urandom);
			req.day = 5'($urandom);
			req.month = 4'($urandom);
			req.year = 14'($urandom);
		end else if (roll < 10) begin
			req.command = CMD_NOP;
		end else if (roll < 32) begin
			req.command = CMD_SET;
		end else if (roll < 62) begin
			req.command = CMD_ADVANCE;
			// small offsets keep the year in range; a few full ones walk far
			if ($urandom_range(14) != 0)
				req.day_delta = 16'($urandom_range(400));
			if ($urandom_range(9) != 0)
				req.month_delta = 10'($urandom_range(30));
			if ($urandom_range(19) != 0)
				req.year_delta = 10'($urandom_range(40));
		end else begin
			req.command = CMD_DIFF;
			// targets mostly a little before the stored date, sometimes after it
			if ($urandom_range(9) != 0) begin
				back_max = (cal_year < 300) ? cal_year : 300;
				req.year = 14'(cal_year - $urandom_range(back_max));
			end
		end
		return req;
	endfunction

	task automatic test_random_traffic(input int unsigned idle_pct,
			input int unsigned stall, input int unsigned count);
		send_idle_pct = idle_pct;
		stall_pct = stall;
		for (int unsigned i = 0; i < count; i++) begin
			// one full hold-off midway so requests also start from a drained block
			if (i == count / 2)
				wait_for_results();
			send_request(random_request());
		end
		wait_for_results();
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part runs without idling on either side
		test_reset_state();
		test_set_dates();
		test_invalid_dates();
		test_advance();
		test_difference();
		test_overflow();
		wait_for_results();

		// random part: no idling, sender idle, receiver stalling, both
		test_random_traffic(0, 0, 28);
		test_random_traffic(62, 0, 28);
		test_random_traffic(0, 62, 28);
		test_random_traffic(24, 24, 28);

		stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("requests: %0d set, %0d advance, %0d difference, %0d unused command",
			cmd_seen[CMD_SET], cmd_seen[CMD_ADVANCE], cmd_seen[CMD_DIFF], cmd_seen[CMD_NOP]);
		$display("results: %0d ok, %0d invalid date, %0d target after, %0d year overflow",
			status_seen[ST_OK], status_seen[ST_INVALID], status_seen[ST_AFTER],
			status_seen[ST_OVERFLOW]);
		if (mismatches == 0 && expected_dates.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
design/cda_pkg.sv
design/cda_stream_if.sv
design/calendar_date_adder.sv
sim/tb.sv
